// ----- design/sgb_pkg.sv -----
// Package for the separable Gaussian smoothing unit: register codes, state
// codes, reset values and datapath widths shared by the design files.
// Depends on nothing.
package sgb_pkg;

  // Default sizing handed to the top level parameters.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HALF_DEF  = 4;
  localparam int MAX_HEIGHT    = 1024;

  // Port and register widths fixed by the interface.
  localparam int PIX_W      = 8;
  localparam int HW_W       = 3;
  localparam int COEF_W     = 16;
  localparam int GEOM_W     = 11;
  localparam int ROW_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_COEF   = 5;
  localparam int COEF_IDX_W = 3;

  // Datapath widths, sized for a kernel of up to nine taps.
  localparam int H_W        = 24;  // row pass result, unsigned 8.16
  localparam int SUM_W      = 20;  // sum of up to nine Q0.16 weights
  localparam int ACC_W      = 44;  // column pass dot product
  localparam int ROW_DOT_W  = 28;  // row pass dot product
  localparam int QUOT_W     = 24;  // widest quotient (row pass)
  localparam int COL_QUOT_W = 8;   // column pass quotient
  localparam int DIV_CNT_W  = 5;

  // Reset values of the configuration registers.
  localparam logic [HW_W-1:0]   HALF_RST        = 3'd2;
  localparam logic [COEF_W-1:0] COEF_CENTER_RST = 16'd51550;
  localparam logic [COEF_W-1:0] COEF_ONE_RST    = 16'd6977;
  localparam logic [COEF_W-1:0] COEF_TWO_RST    = 16'd17;
  localparam logic [COEF_W-1:0] COEF_THREE_RST  = 16'd0;
  localparam logic [COEF_W-1:0] COEF_FOUR_RST   = 16'd0;
  localparam logic [GEOM_W-1:0] IMG_W_RST       = 11'd1024;
  localparam logic [GEOM_W-1:0] IMG_H_RST       = 11'd1024;

  // Input item kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH   = 3'd0,
    REG_COEF_CENTER  = 3'd1,
    REG_COEF_ONE     = 3'd2,
    REG_COEF_TWO     = 3'd3,
    REG_COEF_THREE   = 3'd4,
    REG_COEF_FOUR    = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_INIT,
    ST_ROW_MAC,
    ST_ROW_END,
    ST_ROW_WR,
    ST_DIV,
    ST_COL_INIT,
    ST_COL_RD,
    ST_COL_MAC,
    ST_COL_END,
    ST_OUT
  } state_e;

endpackage

// ----- design/separable_gaussian_blur_unit.sv -----
// Separable Gaussian smoothing unit; uses sgb_pkg. One transaction at a time.
// A pixel runs no row pass, one, or up to hw+1 at a row end, and then a column pass
// if it releases an output; a drain of a complete frame runs a column pass. A zero
// weight sum skips the serial divider; a result waits while the output register is full.
// Output lags input by hw*width+hw pixels. Reset (asynchronous, active low) loads
// the default kernel and geometry and zeroes all positions; no memory clearing pass.
module separable_gaussian_blur_unit #(
  parameter int MAX_WIDTH = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF  = sgb_pkg::MAX_HALF_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input item channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [sgb_pkg::PIX_W-1:0]      pixel_in_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sgb_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                           frame_end_o
);
  import sgb_pkg::*;

  // The line memory keeps one row of horizontal results per row slot; a row
  // slot is the row number modulo the window height, tracked by counters.
  localparam int WIN    = 2 * MAX_HALF + 1;
  localparam int DEPTH  = WIN * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(WIN);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int EW     = ((W_W > GEOM_W) ? W_W : GEOM_W) + 1;
  localparam int T_W    = $clog2(MAX_HALF + 1) + 1;
  localparam int J_W    = SLOT_W + 1;
  localparam int XC_W   = CW + 2;
  localparam int RS_W   = ROW_W + 1;
  localparam int RCV_W  = W_W + ROW_W;
  localparam int PROD_W = H_W + COEF_W;

  // Configuration registers. Writes are accepted at any time; the user only
  // writes while the unit is idle. Geometry writes abandon the current frame.
  logic [HW_W-1:0]   half_q;
  logic [COEF_W-1:0] coef_q [NUM_COEF];
  logic [GEOM_W-1:0] img_w_q;
  logic [GEOM_W-1:0] img_h_q;
  logic              geom_wr;

  assign cfg_ready_o = 1'b1;
  assign geom_wr = cfg_valid_i &&
                   ((cfg_reg_e'(cfg_index_i) == REG_HALF_WIDTH) ||
                    (cfg_reg_e'(cfg_index_i) == REG_IMAGE_WIDTH) ||
                    (cfg_reg_e'(cfg_index_i) == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= HALF_RST;
      coef_q[0] <= COEF_CENTER_RST;
      coef_q[1] <= COEF_ONE_RST;
      coef_q[2] <= COEF_TWO_RST;
      coef_q[3] <= COEF_THREE_RST;
      coef_q[4] <= COEF_FOUR_RST;
      img_w_q   <= IMG_W_RST;
      img_h_q   <= IMG_H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HALF_WIDTH:   half_q    <= cfg_data_i[HW_W-1:0];
        REG_COEF_CENTER:  coef_q[0] <= cfg_data_i;
        REG_COEF_ONE:     coef_q[1] <= cfg_data_i;
        REG_COEF_TWO:     coef_q[2] <= cfg_data_i;
        REG_COEF_THREE:   coef_q[3] <= cfg_data_i;
        REG_COEF_FOUR:    coef_q[4] <= cfg_data_i;
        REG_IMAGE_WIDTH:  img_w_q   <= cfg_data_i[GEOM_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q   <= cfg_data_i[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: half width saturates, width and height are clamped.
  logic [HW_W-1:0]  eff_hw;
  logic [W_W-1:0]   eff_w;
  logic [ROW_W-1:0] eff_h;

  always_comb begin
    eff_hw = (half_q > HW_W'(MAX_HALF)) ? HW_W'(MAX_HALF) : half_q;
    if (img_w_q == '0) begin
      eff_w = W_W'(1);
    end else if (EW'(img_w_q) > EW'(MAX_WIDTH)) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(img_w_q);
    end
    if (img_h_q == '0) begin
      eff_h = ROW_W'(1);
    end else if ((ROW_W + 1)'(img_h_q) > (ROW_W + 1)'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(img_h_q);
    end
  end

  // Stream positions. rcv_q counts the pixels received in this frame.
  logic [ROW_W-1:0]  in_row_q, out_row_q;
  logic [CW-1:0]     in_col_q, out_col_q;
  logic [SLOT_W-1:0] in_slot_q, out_slot_q;
  logic [RCV_W-1:0]  rcv_q;

  state_e state_q, state_d;
  logic   in_ready, mem_we, mem_re, out_load;
  logic   out_valid_q;

  // Decisions taken when a pixel is accepted.
  logic             in_done, eor, cur_ge_hw, hw_nz, has_row, emit_now, accept_pix;
  logic [CW-1:0]    xs, xe;
  logic [RCV_W-1:0] lag, rcv_inc;

  always_comb begin
    in_done   = (in_row_q >= eff_h);
    eor       = ((EW'(in_col_q) + EW'(1)) >= EW'(eff_w));
    cur_ge_hw = (EW'(in_col_q) >= EW'(eff_hw));
    hw_nz     = (eff_hw != '0);
    has_row   = cur_ge_hw || (eor && hw_nz);
    xs        = cur_ge_hw ? CW'(in_col_q - CW'(eff_hw)) : '0;
    xe        = (eor && hw_nz) ? in_col_q : CW'(in_col_q - CW'(eff_hw));
    lag       = RCV_W'(eff_hw) * RCV_W'(eff_w) + RCV_W'(eff_hw);
    rcv_inc   = rcv_q + RCV_W'(1);
    emit_now  = (rcv_inc > lag);
  end

  assign accept_pix = in_ready && in_valid_i && (kind_i == KIND_PIXEL) && !in_done;

  // Output position bookkeeping.
  logic out_last, out_eol;

  assign out_eol  = ((EW'(out_col_q) + EW'(1)) >= EW'(eff_w));
  assign out_last = (((ROW_W + 1)'(out_row_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(eff_h))
                    && out_eol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      rcv_q      <= '0;
    end else if (geom_wr || (out_load && out_last)) begin
      // A new frame starts after its last output or a geometry change.
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_slot_q <= '0;
      rcv_q      <= '0;
    end else begin
      if (accept_pix) begin
        rcv_q <= rcv_inc;
        if (eor) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + ROW_W'(1);
          in_slot_q <= (in_slot_q == SLOT_W'(WIN - 1)) ? '0 : in_slot_q + SLOT_W'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (out_load) begin
        if (out_eol) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + ROW_W'(1);
          out_slot_q <= (out_slot_q == SLOT_W'(WIN - 1)) ? '0 : out_slot_q + SLOT_W'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // Working registers of the tap loop and the divider.
  logic [PIX_W-1:0]     win_q [WIN];
  logic [CW-1:0]        cur_q, x_q, xe_q;
  logic [SLOT_W-1:0]    slot_q, rslot_q;
  logic                 emit_q, pass_col_q;
  logic [T_W-1:0]       tap_q;
  logic [XC_W-1:0]      colp_q;
  logic [J_W-1:0]       jp_q;
  logic [RS_W-1:0]      rrow_q;
  logic [ACC_W-1:0]     acc_q;
  logic [SUM_W-1:0]     sum_q;
  logic [H_W-1:0]       ctr_q;
  logic [SUM_W-1:0]     rem_q;
  logic [QUOT_W-1:0]    num_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [H_W-1:0]       rd_q;

  // One shared multiplier serves both passes.
  logic [T_W-1:0]        tap_abs;
  logic [COEF_W-1:0]     wt;
  logic [PIX_W-1:0]      win_pix;
  logic [H_W-1:0]        mul_a;
  logic [PROD_W-1:0]     prod;
  logic                  row_tap_ok, col_tap_ok, tap_ok, tap_last, sum_zero;
  logic [SUM_W:0]        trial;
  logic                  qbit;
  logic [SLOT_W:0]       rslot_init;

  always_comb begin
    tap_abs    = tap_q[T_W-1] ? T_W'('0 - tap_q) : tap_q;
    wt         = coef_q[COEF_IDX_W'(tap_abs)];
    win_pix    = win_q[jp_q[SLOT_W-1:0]];
    mul_a      = (state_q == ST_ROW_MAC) ? H_W'(win_pix) : rd_q;
    prod       = PROD_W'(mul_a) * PROD_W'(wt);
    row_tap_ok = !colp_q[XC_W-1] && !jp_q[J_W-1];
    col_tap_ok = !rrow_q[RS_W-1] && (rrow_q[ROW_W-1:0] < eff_h);
    tap_ok     = (state_q == ST_ROW_MAC) ? row_tap_ok : col_tap_ok;
    tap_last   = (tap_q == T_W'(eff_hw));
    sum_zero   = (sum_q == '0);
    trial      = {rem_q, num_q[QUOT_W-1]};
    qbit       = (trial >= {1'b0, sum_q});
    rslot_init = (SLOT_W + 1)'(out_slot_q) + (SLOT_W + 1)'(WIN) - (SLOT_W + 1)'(eff_hw);
    if (rslot_init >= (SLOT_W + 1)'(WIN)) begin
      rslot_init = rslot_init - (SLOT_W + 1)'(WIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_pix) begin
      for (int i = WIN - 1; i > 0; i--) begin
        win_q[i] <= win_q[i - 1];
      end
      win_q[0] <= pixel_in_i;
      cur_q    <= in_col_q;
      slot_q   <= in_slot_q;
      x_q      <= xs;
      xe_q     <= xe;
      emit_q   <= emit_now;
    end
    case (state_q)
      ST_ROW_INIT: begin
        tap_q  <= T_W'('0) - T_W'(eff_hw);
        colp_q <= XC_W'(x_q) - XC_W'(eff_hw);
        jp_q   <= J_W'(cur_q - x_q) + J_W'(eff_hw);
        acc_q  <= '0;
        sum_q  <= '0;
      end
      ST_COL_INIT: begin
        tap_q   <= T_W'('0) - T_W'(eff_hw);
        rrow_q  <= RS_W'(out_row_q) - RS_W'(eff_hw);
        rslot_q <= SLOT_W'(rslot_init);
        acc_q   <= '0;
        sum_q   <= '0;
      end
      ST_ROW_MAC, ST_COL_MAC: begin
        if (tap_ok) begin
          acc_q <= acc_q + ACC_W'(prod);
          sum_q <= sum_q + SUM_W'(wt);
        end
        // The center tap is always inside the frame; keep it for the
        // zero weight sum case.
        if (tap_q == '0) begin
          ctr_q <= mul_a;
        end
        tap_q   <= tap_q + T_W'(1);
        colp_q  <= colp_q + XC_W'(1);
        jp_q    <= jp_q - J_W'(1);
        rrow_q  <= rrow_q + RS_W'(1);
        rslot_q <= (rslot_q == SLOT_W'(WIN - 1)) ? '0 : rslot_q + SLOT_W'(1);
      end
      ST_ROW_END: begin
        pass_col_q <= 1'b0;
        if (sum_zero) begin
          num_q <= {ctr_q[PIX_W-1:0], 16'b0};
        end else begin
          // Quotient of (dot << 16) / sum, 24 bits.
          rem_q     <= acc_q[ROW_DOT_W-1 -: SUM_W];
          num_q     <= {acc_q[PIX_W-1:0], 16'b0};
          div_cnt_q <= DIV_CNT_W'(QUOT_W);
        end
      end
      ST_COL_END: begin
        pass_col_q <= 1'b1;
        if (sum_zero) begin
          num_q <= QUOT_W'(ctr_q[H_W-1 -: PIX_W]);
        end else begin
          // Quotient of (dot >> 16) / sum, 8 bits.
          rem_q     <= acc_q[ACC_W-1 -: SUM_W];
          num_q     <= {acc_q[ACC_W-SUM_W-1 -: COL_QUOT_W], 16'b0};
          div_cnt_q <= DIV_CNT_W'(COL_QUOT_W);
        end
      end
      ST_DIV: begin
        rem_q     <= qbit ? SUM_W'(trial - {1'b0, sum_q}) : trial[SUM_W-1:0];
        num_q     <= {num_q[QUOT_W-2:0], qbit};
        div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      end
      ST_ROW_WR: begin
        x_q <= x_q + CW'(1);
      end
      default: ;
    endcase
  end

  // Line memory of horizontal results, one synchronous read port.
  logic [H_W-1:0]    lines_mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
  assign rd_addr = ADDR_W'(rslot_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(out_col_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lines_mem[wr_addr] <= num_q;
    end
    if (mem_re) begin
      rd_q <= lines_mem[rd_addr];
    end
  end

  // Sequencer. Row writes always finish before the column reads of the same
  // item are issued, so no forwarding path is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          if (kind_i == KIND_DRAIN) begin
            // A drain before the frame is complete is ignored.
            if (in_done) begin
              state_d = ST_COL_INIT;
            end
          end else if (!in_done) begin
            if (has_row) begin
              state_d = ST_ROW_INIT;
            end else if (emit_now) begin
              state_d = ST_COL_INIT;
            end
          end
        end
      end
      ST_ROW_INIT: state_d = ST_ROW_MAC;
      ST_ROW_MAC: begin
        if (tap_last) begin
          state_d = ST_ROW_END;
        end
      end
      ST_ROW_END: state_d = sum_zero ? ST_ROW_WR : ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(1)) begin
          state_d = pass_col_q ? ST_OUT : ST_ROW_WR;
        end
      end
      ST_ROW_WR: begin
        mem_we = 1'b1;
        if (x_q == xe_q) begin
          state_d = emit_q ? ST_COL_INIT : ST_IDLE;
        end else begin
          state_d = ST_ROW_INIT;
        end
      end
      ST_COL_INIT: state_d = ST_COL_RD;
      ST_COL_RD: begin
        mem_re  = 1'b1;
        state_d = ST_COL_MAC;
      end
      ST_COL_MAC: state_d = tap_last ? ST_COL_END : ST_COL_RD;
      ST_COL_END: state_d = sum_zero ? ST_OUT : ST_DIV;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = in_ready;

  // Output register: the next item is taken while a result waits here.
  logic [PIX_W-1:0] pix_out_q;
  logic             frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pix_out_q   <= num_q[PIX_W-1:0];
      frame_end_q <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_out_q;
  assign frame_end_o = frame_end_q;

  // Checks on the sequencer and the position bookkeeping.
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q != '0))
    else $error("divider running with an exhausted count");

  a_row_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (x_q <= cur_q))
    else $error("row result written ahead of the newest pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_OUT) && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("pending result overwrote the output register");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last) |=>
      ((in_row_q == '0) && (in_col_q == '0) && (out_row_q == '0) && (rcv_q == '0)))
    else $error("positions not cleared after the last pixel of a frame");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_pix |=> ((in_slot_q < SLOT_W'(WIN)) && (out_slot_q < SLOT_W'(WIN))))
    else $error("row slot counter left the window");

endmodule

// ----- tb/sv/separable_gaussian_blur_unit_test.sv -----
// Self-checking testbench for separable_gaussian_blur_unit: a bit-exact
// Gaussian smoothing predictor and a scoreboard of pending smoothed pixels.
// Depends on sgb_pkg and the design files of the unit.
`timescale 1ns / 100ps

// One smoothed pixel that the unit still owes.
typedef struct packed {
  logic [7:0] pixel;
  logic       frame_end;
} smoothed_pixel_t;

class blur_scoreboard;
  // Register copies.
  bit [2:0]  half_width;
  bit [15:0] coef [5];
  bit [10:0] img_w, img_h;
  // Shadow state of the filter.
  bit [7:0]  row_win [9];
  bit [23:0] lines [9*1024];
  int unsigned in_row, in_col, out_row, out_col;
  smoothed_pixel_t pending_q [$];
  int fails;

  function new();
    half_width = sgb_pkg::HALF_RST;
    coef[0] = sgb_pkg::COEF_CENTER_RST;
    coef[1] = sgb_pkg::COEF_ONE_RST;
    coef[2] = sgb_pkg::COEF_TWO_RST;
    coef[3] = sgb_pkg::COEF_THREE_RST;
    coef[4] = sgb_pkg::COEF_FOUR_RST;
    img_w = sgb_pkg::IMG_W_RST;
    img_h = sgb_pkg::IMG_H_RST;
    foreach (row_win[i]) row_win[i] = '0;
    foreach (lines[i]) lines[i] = '0;
    clear_positions();
    fails = 0;
  endfunction

  function void clear_positions();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  function int kern_half();
    return (half_width > 4) ? 4 : half_width;
  endfunction

  function int frame_w();
    return (img_w < 1) ? 1 : ((img_w > 1024) ? 1024 : img_w);
  endfunction

  function int frame_h();
    return (img_h < 1) ? 1 : ((img_h > 1024) ? 1024 : img_h);
  endfunction

  function longint unsigned weight(int d);
    if (d < 0) d = -d;
    return (d <= 4) ? coef[d] : 0;
  endfunction

  function bit frame_received();
    return in_row >= frame_h();
  endfunction

  function void note_config(sgb_pkg::cfg_reg_e idx, bit [15:0] val);
    case (idx)
      sgb_pkg::REG_HALF_WIDTH: begin
        half_width = val[2:0];
        clear_positions();
      end
      sgb_pkg::REG_COEF_CENTER: coef[0] = val;
      sgb_pkg::REG_COEF_ONE: coef[1] = val;
      sgb_pkg::REG_COEF_TWO: coef[2] = val;
      sgb_pkg::REG_COEF_THREE: coef[3] = val;
      sgb_pkg::REG_COEF_FOUR: coef[4] = val;
      sgb_pkg::REG_IMAGE_WIDTH: begin
        img_w = val[10:0];
        clear_positions();
      end
      sgb_pkg::REG_IMAGE_HEIGHT: begin
        img_h = val[10:0];
        clear_positions();
      end
      default: ;
    endcase
  endfunction

  // Horizontal pass for column x of row r while the newest pixel is at column cur.
  function void smooth_row(int r, int x, int cur, int hw, int w);
    longint unsigned dot, wsum, val, wt;
    int col, j;
    dot = 0;
    wsum = 0;
    for (int t = -hw; t <= hw; t++) begin
      col = x + t;
      j = cur - col;
      if (col >= 0 && col < w && j >= 0 && j < 9) begin
        wt = weight(t);
        dot += longint'(row_win[j]) * wt;
        wsum += wt;
      end
    end
    if (wsum == 0) begin
      j = cur - x;
      val = (j >= 0 && j < 9) ? (longint'(row_win[j]) << 16) : 0;
    end else begin
      val = (dot << 16) / wsum;
    end
    lines[(r % 9) * 1024 + (x % 1024)] = val[23:0];
  endfunction

  // Vertical pass for the next output position; queues the expected pixel.
  function void smooth_column();
    longint unsigned dot, wsum, val, wt;
    int hw, h, w, c, rr;
    bit last;
    smoothed_pixel_t px;
    hw = kern_half();
    h = frame_h();
    w = frame_w();
    c = out_col % 1024;
    dot = 0;
    wsum = 0;
    for (int t = -hw; t <= hw; t++) begin
      rr = out_row + t;
      if (rr >= 0 && rr < h) begin
        wt = weight(t);
        dot += longint'(lines[(rr % 9) * 1024 + c]) * wt;
        wsum += wt;
      end
    end
    if (wsum == 0) val = longint'(lines[(out_row % 9) * 1024 + c]) >> 16;
    else val = dot / (wsum << 16);
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    px.pixel = val[7:0];
    px.frame_end = last;
    pending_q.push_back(px);
    if (last) begin
      clear_positions();
    end else if (++out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  // Returns 1 when the transaction was not ignored by the unit.
  function bit note_input(bit kind, bit [7:0] pix);
    int hw, w, h, cur, row, x;
    longint unsigned received;
    hw = kern_half();
    w = frame_w();
    h = frame_h();
    if (kind == sgb_pkg::KIND_DRAIN) begin
      if (in_row < h) return 0;
      smooth_column();
      return 1;
    end
    if (in_row >= h) return 0;
    for (int j = 8; j > 0; j--) row_win[j] = row_win[j-1];
    row_win[0] = pix;
    cur = in_col;
    row = in_row;
    if (cur >= hw) smooth_row(row, cur - hw, cur, hw, w);
    // At the end of a row the right-hand columns are finished off.
    if (cur + 1 >= w && hw > 0) begin
      x = cur - hw + 1;
      if (x < 0) x = 0;
      for (; x <= cur; x++) smooth_row(row, x, cur, hw, w);
    end
    received = longint'(row) * w + cur + 1;
    if (++in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (received > longint'(hw) * w + hw) smooth_column();
    return 1;
  endfunction

  function void check_result(bit [7:0] pix, bit fe);
    smoothed_pixel_t exp_px;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result pixel=%0d frame_end=%0d", $time, pix, fe);
      fails++;
      return;
    end
    exp_px = pending_q.pop_front();
    if (exp_px.pixel !== pix) begin
      $display("%0t: pixel_out expected %0d actual %0d", $time, exp_px.pixel, pix);
      fails++;
    end
    if (exp_px.frame_end !== fe) begin
      $display("%0t: frame_end expected %0d actual %0d", $time, exp_px.frame_end, fe);
      fails++;
    end
  endfunction
endclass

module separable_gaussian_blur_unit_test;
  import sgb_pkg::*;

  // Worst single transaction: five row passes with nine taps plus a column pass.
  localparam int SETTLE_CYCLES = 400;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  cfg_reg_e         cfg_index_i = REG_HALF_WIDTH;
  logic [15:0]      cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             kind_i = KIND_PIXEL;
  logic [7:0]       pixel_in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [7:0]       pixel_out_o;
  logic             frame_end_o;

  blur_scoreboard   sb = new();
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               items_sent = 0;

  separable_gaussian_blur_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o),
    .frame_end_o(frame_end_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The receiver decides its ready level at each falling edge, so stalls land
  // on every phase of the unit's serial work.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Results are sampled at the rising edge and handed to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(pixel_out_o, frame_end_o);
  end

  // Waits until no smoothed pixel is owed, then lets the unit finish any row
  // pass that a pixel without an output may still have running.
  task automatic wait_quiet();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write transaction; the caller makes sure the unit is idle.
  task automatic write_reg(cfg_reg_e idx, bit [15:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_kernel(bit [2:0] hw, bit [15:0] c0, bit [15:0] c1, bit [15:0] c2,
                             bit [15:0] c3, bit [15:0] c4, bit [10:0] w, bit [10:0] h);
    wait_quiet();
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_COEF_CENTER, c0);
    write_reg(REG_COEF_ONE, c1);
    write_reg(REG_COEF_TWO, c2);
    write_reg(REG_COEF_THREE, c3);
    write_reg(REG_COEF_FOUR, c4);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Sends one input transaction. Valid drops once the transaction is taken; a
  // transaction that follows at once raises it again in the same time step, so
  // back-to-back transactions keep it high across the boundary.
  task automatic send_item(bit kind, bit [7:0] pix);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = kind;
    pixel_in_i = pix;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.note_input(kind, pix)) items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain_frame();
    while (sb.frame_received()) send_item(KIND_DRAIN, $urandom_range(0, 255));
  endtask

  function automatic bit [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Random frame: mostly complete frames, with stray drains, surplus pixels
  // and the odd frame abandoned halfway by a geometry write.
  task automatic random_frame();
    int w, h, n;
    bit abandon;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    h = $urandom_range(1, 8);
    load_kernel(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4),
                rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), w, h);
    abandon = ($urandom_range(0, 11) == 0);
    n = abandon ? $urandom_range(1, w * h) : w * h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) send_item(KIND_DRAIN, $urandom_range(0, 255));
      send_item(KIND_PIXEL, $urandom_range(0, 255));
    end
    if (abandon) return;
    if ($urandom_range(0, 3) == 0) send_item(KIND_PIXEL, $urandom_range(0, 255));
    drain_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset kernel on the default full-size frame: too few pixels for any
    // output, then the frame is abandoned by the next geometry write.
    send_item(KIND_PIXEL, 8'd0);
    send_item(KIND_PIXEL, 8'd255);
    send_item(KIND_DRAIN, 8'd0);

    // Zero half width is a plain copy; early drain and surplus pixel included.
    load_kernel(3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 11'd3, 11'd2);
    send_item(KIND_PIXEL, 8'd0);
    send_item(KIND_DRAIN, 8'd7);
    send_item(KIND_PIXEL, 8'd255);
    send_item(KIND_PIXEL, 8'd128);
    send_item(KIND_PIXEL, 8'd1);
    send_item(KIND_PIXEL, 8'd254);
    send_item(KIND_PIXEL, 8'd127);
    send_item(KIND_PIXEL, 8'd85);

    // Oversized half width saturates; all weights zero copies the center.
    load_kernel(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 11'd2, 11'd2);
    repeat (4) send_item(KIND_PIXEL, 8'd255);
    send_item(KIND_PIXEL, 8'd9);
    drain_frame();

    // Full-scale taps on an edge pattern, narrow enough to drop outer taps.
    load_kernel(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd3, 11'd2);
    for (int i = 0; i < 6; i++) send_item(KIND_PIXEL, i[0] ? 8'd255 : 8'd0);
    drain_frame();

    // Out-of-range geometry clamps: zero and oversized sizes, then abandon.
    load_kernel(3'd1, 16'd1000, 16'd1, 16'd0, 16'd0, 16'd0, 11'd0, 11'd0);
    send_item(KIND_PIXEL, 8'd200);
    drain_frame();
    load_kernel(3'd3, 16'd500, 16'd400, 16'd300, 16'd200, 16'd100, 11'd2047, 11'd2047);
    send_item(KIND_PIXEL, 8'd77);
    send_item(KIND_PIXEL, 8'd78);

    // Random frames in three idling phases.
    items_sent = 0;
    send_idle_pct = 8;
    recv_idle_pct = 57;
    while (items_sent < 630) random_frame();
    send_idle_pct = 57;
    recv_idle_pct = 8;
    while (items_sent < 1270) random_frame();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 1900) random_frame();

    in_valid_i = 1'b0;
    wait_quiet();
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
